@@ design/sirsga_pkg.sv @@
package sirsga_pkg;

  // Cell encoding shared by the line store and the update stage
  typedef enum logic [1:0] {
    CELL_WALL = 2'd0,
    CELL_SUSC = 2'd1,
    CELL_INF  = 2'd2,
    CELL_REM  = 2'd3
  } cell_t;

  // Stencil cells read back from the line store for one update
  typedef struct packed {
    cell_t centre;
    cell_t north;
    cell_t west;
    cell_t east;
  } nbr_t;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned PROB_BITS_DEF  = 16;

  localparam int unsigned DIM_BITS  = 11;
  localparam int unsigned PROB_W    = 16;
  localparam int unsigned CELL_W    = 2;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_INFECT   = 3'd2;
  localparam logic [2:0] REG_REMOVE   = 3'd3;
  localparam logic [2:0] REG_REINSERT = 3'd4;

  // Reset values: 0.2, 0.2 and 0.001 in Q0.16
  localparam logic [DIM_BITS-1:0] WIDTH_RESET    = 11'd80;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET   = 11'd80;
  localparam logic [PROB_W-1:0]   INFECT_RESET   = 16'd13107;
  localparam logic [PROB_W-1:0]   REMOVE_RESET   = 16'd13107;
  localparam logic [PROB_W-1:0]   REINSERT_RESET = 16'd66;

endpackage

@@ design/sirsga_line_store.sv @@
module sirsga_line_store #(
  parameter int unsigned MAX_WIDTH = sirsga_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW        = $clog2(2 * MAX_WIDTH + 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  sirsga_pkg::cell_t wr_cell,
  input  logic [AW-1:0]     dist_w,
  input  logic [AW-1:0]     dist_w1,
  input  logic [AW-1:0]     dist_w2,
  input  logic [AW-1:0]     dist_2w1,
  output sirsga_pkg::nbr_t  nbr
);
  import sirsga_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_WIDTH + 2;

  logic [AW-1:0] ptr_r;
  logic [AW-1:0] ptr_nxt;
  logic [AW-1:0] addr_east;
  logic [AW-1:0] addr_centre;
  logic [AW-1:0] addr_west;
  logic [AW-1:0] addr_north;
  cell_t         mem_a [DEPTH];
  cell_t         mem_b [DEPTH];
  nbr_t          nbr_r;

  // Ring address k entries behind the write pointer
  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] p, input logic [AW-1:0] k);
    logic [AW:0] diff;
    diff = {1'b0, p} - {1'b0, k};
    if (diff[AW]) begin
      return AW'(diff + (AW+1)'(DEPTH));
    end
    return AW'(diff);
  endfunction

  always_comb begin
    addr_east   = back_addr(ptr_r, dist_w);
    addr_centre = back_addr(ptr_r, dist_w1);
    addr_west   = back_addr(ptr_r, dist_w2);
    addr_north  = back_addr(ptr_r, dist_2w1);
    ptr_nxt     = (32'(ptr_r) == DEPTH - 1) ? '0 : ptr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (wr_en) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Two copies, each with two read ports; every entry is written to both
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[ptr_r] <= wr_cell;
      mem_b[ptr_r] <= wr_cell;
      nbr_r.east   <= mem_a[addr_east];
      nbr_r.centre <= mem_a[addr_centre];
      nbr_r.west   <= mem_b[addr_west];
      nbr_r.north  <= mem_b[addr_north];
    end
  end

  assign nbr = nbr_r;

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) < DEPTH)
    else $error("line store pointer outside ring");

endmodule

@@ design/sirs_grid_automaton_step.sv @@
// Emission: the next state of the cell at raster position p is carried by the transaction
//   of input p+width+1, then passes through stage 1 and the result queue to out_valid.
// Throughput: one cell per cycle while in_ready is high, limited by the single line store write port.
// Reset (synchronous, rst_n low): counters, ring pointer and result queue cleared,
//   registers back to width 80, height 80, probabilities 0.2 / 0.2 / 0.001.
// Line store contents are not cleared; no clearing pass follows reset.
module sirs_grid_automaton_step #(
  parameter int unsigned MAX_WIDTH  = sirsga_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sirsga_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned PROB_BITS  = sirsga_pkg::PROB_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sirsga_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sirsga_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sirsga_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  // cell stream in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sirsga_pkg::CELL_W-1:0]       in_cell_state,
  input  logic [sirsga_pkg::PROB_W-1:0]       in_random_word,
  // next generation out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sirsga_pkg::CELL_W-1:0]       out_next_state,
  output logic                                out_frame_last
);
  import sirsga_pkg::*;

  localparam int unsigned DW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = $clog2(2 * MAX_WIDTH + 2);
  localparam int unsigned PW = PROB_W + 3;   // probability times a count of up to four
  localparam logic [PROB_W-1:0] PMASK = PROB_W'((64'd1 << PROB_BITS) - 64'd1);
  localparam int unsigned QDEPTH = 3;

  typedef struct packed {
    cell_t state;
    logic  last;
  } res_t;

  // Saturate the grid size into the supported range
  function automatic logic [DW-1:0] clamp_w(input logic [DIM_BITS-1:0] v);
    if (32'(v) < 3) begin
      return DW'(3);
    end else if (32'(v) > MAX_WIDTH) begin
      return DW'(MAX_WIDTH);
    end
    return DW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [DIM_BITS-1:0] v);
    if (32'(v) < 3) begin
      return HW'(3);
    end else if (32'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v);
  endfunction

  function automatic logic [1:0] q_bump(input logic [1:0] i);
    return (32'(i) == QDEPTH - 1) ? 2'd0 : i + 2'd1;
  endfunction

  localparam logic [DW-1:0] W_RST = clamp_w(WIDTH_RESET);
  localparam logic [HW-1:0] H_RST = clamp_h(HEIGHT_RESET);

  // ---------------------------------------------------------------------------
  // Configuration registers. The raw values are kept for read-back; the clamped
  // sizes are worked out when each size is written, the four ring distances when
  // width is written, so that the read addresses need only one subtract each.
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0] width_r;
  logic [DIM_BITS-1:0] height_r;
  logic [PROB_W-1:0]   infect_r;
  logic [PROB_W-1:0]   remove_r;
  logic [PROB_W-1:0]   reinsert_r;
  logic [DW-1:0]       w_r;
  logic [HW-1:0]       h_r;
  logic [AW-1:0]       dist_w_r;
  logic [AW-1:0]       dist_w1_r;
  logic [AW-1:0]       dist_w2_r;
  logic [AW-1:0]       dist_2w1_r;
  logic [DW-1:0]       w_src;
  logic [HW-1:0]       h_src;
  logic [2:0]          reg_idx;
  logic                cfg_wr;
  logic                load_w;
  logic                load_h;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign load_w  = !rst_n || (cfg_wr && reg_idx == REG_WIDTH);
  assign load_h  = !rst_n || (cfg_wr && reg_idx == REG_HEIGHT);
  assign w_src   = rst_n ? clamp_w(pwdata[DIM_BITS-1:0]) : W_RST;
  assign h_src   = rst_n ? clamp_h(pwdata[DIM_BITS-1:0]) : H_RST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      infect_r   <= INFECT_RESET;
      remove_r   <= REMOVE_RESET;
      reinsert_r <= REINSERT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:    width_r    <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT:   height_r   <= pwdata[DIM_BITS-1:0];
        REG_INFECT:   infect_r   <= pwdata[PROB_W-1:0];
        REG_REMOVE:   remove_r   <= pwdata[PROB_W-1:0];
        REG_REINSERT: reinsert_r <= pwdata[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived size values, loaded at reset as well as on a write
  always_ff @(posedge clk) begin
    if (load_w) begin
      w_r        <= w_src;
      dist_w_r   <= AW'(32'(w_src));
      dist_w1_r  <= AW'(32'(w_src) + 1);
      dist_w2_r  <= AW'(32'(w_src) + 2);
      dist_2w1_r <= AW'(2 * 32'(w_src) + 1);
    end
    if (load_h) begin
      h_r <= h_src;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:    prdata = APB_DATA_W'(width_r);
      REG_HEIGHT:   prdata = APB_DATA_W'(height_r);
      REG_INFECT:   prdata = APB_DATA_W'(infect_r);
      REG_REMOVE:   prdata = APB_DATA_W'(remove_r);
      REG_REINSERT: prdata = APB_DATA_W'(reinsert_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input stage: raster position and the decisions that depend only on it.
  // The cell emitted on input n sits width+1 positions back; it is interior
  // only when the current column is at least two and the row at least two,
  // so that its own column and row are neither the first nor the last.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_r;
  logic [RW-1:0] row_nxt;
  logic          accept;
  logic          emit;
  logic          interior;
  logic          row_end;
  logic          frame_end;
  cell_t         in_cell;
  cell_t         south_r;      // previous input, the south neighbour
  logic [1:0]    cnt_r;
  logic          s1_v_r;

  assign in_cell  = cell_t'(in_cell_state);
  // Room for the transaction in stage 1 and in the result queue
  assign in_ready = ({1'b0, cnt_r} + 3'(s1_v_r)) <= 3'd2;
  assign accept   = in_valid && in_ready;

  always_comb begin
    row_end   = (32'(col_r) + 1) >= 32'(w_r);
    frame_end = row_end && ((32'(row_r) + 1) >= 32'(h_r));
    emit      = (32'(row_r) >= 2) || (32'(row_r) == 1 && col_r != '0);
    interior  = (32'(col_r) >= 2) && (32'(col_r) < 32'(w_r)) &&
                (32'(row_r) >= 2) && (32'(row_r) < 32'(h_r));
    priority if (frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = RW'(32'(row_r) + 1);
    end else begin
      col_nxt = CW'(32'(col_r) + 1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: every accepted cell is written; the four far stencil cells are
  // read in the same cycle and come back registered for stage 1.
  // ---------------------------------------------------------------------------
  nbr_t nbr;

  sirsga_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_cell  (in_cell),
    .dist_w   (dist_w_r),
    .dist_w1  (dist_w1_r),
    .dist_w2  (dist_w2_r),
    .dist_2w1 (dist_2w1_r),
    .nbr      (nbr)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: travels alongside the memory read. Only emitting transactions
  // become valid here; the others have already done their work (the write).
  // ---------------------------------------------------------------------------
  logic               s1_int_r;
  logic               s1_last_r;
  logic [PROB_W-1:0]  s1_rnd_r;
  cell_t              s1_south_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_int_r   <= interior;
      s1_last_r  <= frame_end;
      s1_rnd_r   <= in_random_word & PMASK;
      s1_south_r <= south_r;
      south_r    <= in_cell;
    end
  end

  // Transition rule: count infected and susceptible neighbours; compare the random
  // word at full width against the probability, times the count except for removal.
  logic [2:0]    n_inf;
  logic [2:0]    n_sus;
  logic [PW-1:0] thr_inf;
  logic [PW-1:0] thr_rem;
  logic [PW-1:0] thr_rei;
  logic [PW-1:0] rnd_ext;
  cell_t         next_cell;

  always_comb begin
    n_inf = 3'(s1_south_r == CELL_INF) + 3'(nbr.east == CELL_INF) +
            3'(nbr.west == CELL_INF) + 3'(nbr.north == CELL_INF);
    n_sus = 3'(s1_south_r == CELL_SUSC) + 3'(nbr.east == CELL_SUSC) +
            3'(nbr.west == CELL_SUSC) + 3'(nbr.north == CELL_SUSC);
    thr_inf = PW'(infect_r & PMASK) * PW'(n_inf);
    thr_rem = PW'(remove_r & PMASK);
    thr_rei = PW'(reinsert_r & PMASK) * PW'(n_sus);
    rnd_ext = PW'(s1_rnd_r);
    next_cell = nbr.centre;
    if (s1_int_r) begin
      unique case (nbr.centre)
        CELL_SUSC: if (rnd_ext < thr_inf) next_cell = CELL_INF;
        CELL_INF:  if (rnd_ext < thr_rem) next_cell = CELL_REM;
        CELL_REM:  if (rnd_ext < thr_rei) next_cell = CELL_SUSC;
        CELL_WALL: next_cell = CELL_WALL;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: three entries, enough for one cell per cycle while out_ready takes
  // each result at once; in_ready drops once the queue and stage 1 hold more than two
  // results, so stage 1 always finds a free slot.
  res_t       q_mem [QDEPTH];
  logic [1:0] wr_idx_r;
  logic [1:0] rd_idx_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  res_t       head;

  assign push      = s1_v_r;
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);
  assign out_valid = cnt_r != 2'd0;
  assign head      = q_mem[rd_idx_r];
  assign out_next_state = head.state;
  assign out_frame_last = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_idx_r <= q_bump(wr_idx_r);
      end
      if (pop) begin
        rd_idx_r <= q_bump(rd_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_idx_r] <= '{state: next_cell, last: s1_last_r};
    end
  end

  // Stage 1 never pushes into a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(cnt_r == 2'd3 && s1_v_r))
    else $error("result pushed into full queue");

  // An emitting transaction reaches stage 1 on the next cycle
  a_emit_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit) |=> s1_v_r)
    else $error("emitting transaction lost before stage 1");

  // The last cell of a frame returns the raster position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> (col_r == '0 && row_r == '0))
    else $error("raster position not reset at frame end");

endmodule

@@ test/sirs_generation_checker.sv @@
`timescale 1ns / 100ps

module sirs_generation_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [sirsga_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sirsga_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [sirsga_pkg::CELL_W-1:0]     in_cell_state,
  input  logic [sirsga_pkg::PROB_W-1:0]     in_random_word,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [sirsga_pkg::CELL_W-1:0]     out_next_state,
  input  logic                              out_frame_last,
  output int                                fail_count,
  output int                                pending
);
  import sirsga_pkg::*;

  localparam int unsigned HIST_DEPTH = 2 * MAX_WIDTH_DEF + 2;

  typedef struct packed {
    cell_t state;
    logic  last;
  } gen_cell_t;

  // Recent cells of the stream, newest at hist_ptr - 1
  cell_t               hist [HIST_DEPTH];
  int unsigned         hist_ptr;
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [DIM_BITS-1:0] cols_reg;
  logic [DIM_BITS-1:0] rows_reg;
  logic [PROB_W-1:0]   infect_q;
  logic [PROB_W-1:0]   remove_q;
  logic [PROB_W-1:0]   reinsert_q;
  gen_cell_t           next_gen_due [$];
  gen_cell_t           oldest;
  int                  fails = 0;
  int                  results_seen = 0;

  initial foreach (hist[i]) hist[i] = CELL_WALL;

  function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
    int unsigned d;
    d = 32'(v);
    if (d < 3) return 3;
    if (d > hi) return hi;
    return d;
  endfunction

  function automatic cell_t look_back(int unsigned k);
    return hist[(hist_ptr + HIST_DEPTH - (k % HIST_DEPTH)) % HIST_DEPTH];
  endfunction

  function automatic bit odds_hit(logic [PROB_W-1:0] rnd, logic [PROB_W-1:0] p,
                                  int unsigned n);
    int unsigned r;
    int unsigned lim;
    r = 32'(rnd);
    lim = 32'(p);
    return r < lim * n;
  endfunction

  // Queue the next state due on this transaction, then store the cell and step the position
  function automatic void predict_next_gen(cell_t cell_val, logic [PROB_W-1:0] rnd);
    int unsigned w;
    int unsigned h;
    int unsigned ec;
    int unsigned er;
    int unsigned n_inf;
    int unsigned n_sus;
    bit          row_end;
    bit          frame_end;
    cell_t       centre;
    cell_t       upd;
    cell_t       nbr [4];
    gen_cell_t   due;
    w = clamp_dim(cols_reg, MAX_WIDTH_DEF);
    h = clamp_dim(rows_reg, MAX_HEIGHT_DEF);
    row_end = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (row_pos >= 2 || (row_pos == 1 && col_pos >= 1)) begin
      if (col_pos == 0) begin
        ec = w - 1;
        er = row_pos - 2;
      end else begin
        ec = col_pos - 1;
        er = row_pos - 1;
      end
      centre = look_back(w + 1);
      upd = centre;
      if (ec != 0 && ec < w - 1 && er != 0 && er < h - 1) begin
        nbr[0] = look_back(1);
        nbr[1] = look_back(w);
        nbr[2] = look_back(w + 2);
        nbr[3] = look_back(2 * w + 1);
        n_inf = 0;
        n_sus = 0;
        foreach (nbr[i]) begin
          if (nbr[i] == CELL_INF) n_inf++;
          if (nbr[i] == CELL_SUSC) n_sus++;
        end
        case (centre)
          CELL_SUSC: if (odds_hit(rnd, infect_q, n_inf)) upd = CELL_INF;
          CELL_INF:  if (odds_hit(rnd, remove_q, 1)) upd = CELL_REM;
          CELL_REM:  if (odds_hit(rnd, reinsert_q, n_sus)) upd = CELL_SUSC;
          default: ;
        endcase
      end
      due.state = upd;
      due.last = frame_end;
      next_gen_due.push_back(due);
    end
    hist[hist_ptr] = cell_val;
    hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
    if (frame_end) begin
      col_pos = 0;
      row_pos = 0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hist_ptr = 0;
      col_pos = 0;
      row_pos = 0;
      cols_reg = WIDTH_RESET;
      rows_reg = HEIGHT_RESET;
      infect_q = INFECT_RESET;
      remove_q = REMOVE_RESET;
      reinsert_q = REINSERT_RESET;
      next_gen_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_WIDTH:    cols_reg = pwdata[DIM_BITS-1:0];
          REG_HEIGHT:   rows_reg = pwdata[DIM_BITS-1:0];
          REG_INFECT:   infect_q = pwdata[PROB_W-1:0];
          REG_REMOVE:   remove_q = pwdata[PROB_W-1:0];
          REG_REINSERT: reinsert_q = pwdata[PROB_W-1:0];
          default: ;
        endcase
      end
      // results leave only after stage 1 and the result queue, so pop before push
      if (out_valid && out_ready) begin
        results_seen++;
        if (next_gen_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("result %0d not expected: next_state %0d frame_last %0b",
                     results_seen, out_next_state, out_frame_last);
        end else begin
          oldest = next_gen_due.pop_front();
          if (out_next_state !== oldest.state || out_frame_last !== oldest.last) begin
            fails++;
            if (fails <= 10)
              $display("result %0d: next_state exp %0d got %0d, frame_last exp %0b got %0b",
                       results_seen, oldest.state, out_next_state, oldest.last,
                       out_frame_last);
          end
        end
      end
      if (in_valid && in_ready) predict_next_gen(cell_t'(in_cell_state), in_random_word);
    end
    fail_count <= fails;
    pending <= next_gen_due.size();
  end

endmodule

@@ test/tb_sirs_grid_automaton_step.sv @@
`timescale 1ns / 100ps

module tb_sirs_grid_automaton_step;
  import sirsga_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam int unsigned QUIET_LIMIT   = 5000;  // well above the long receiver hold
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;     // block offers a result after stage 1 and the result queue
  localparam int unsigned DEMO_CELLS    = 25;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CELL_W-1:0]     in_cell_state = '0;
  logic [PROB_W-1:0]     in_random_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CELL_W-1:0]     out_next_state;
  logic                  out_frame_last;

  int                    fail_count;
  int                    pending;

  // Idling knobs and the long receiver hold
  int unsigned           idle_pct = 0;
  int unsigned           stall_pct = 0;
  logic                  hold_toggle = 1'b0;
  logic                  hold_seen = 1'b0;
  int unsigned           hold_left = 0;
  int unsigned           quiet = 0;

  // Raster position as seen by the sender, so it knows where each frame ends
  logic [DIM_BITS-1:0]   cols_set = WIDTH_RESET;
  logic [DIM_BITS-1:0]   rows_set = HEIGHT_RESET;
  int unsigned           cols_eff = 32'(WIDTH_RESET);
  int unsigned           rows_eff = 32'(HEIGHT_RESET);
  int unsigned           col_at = 0;
  int unsigned           row_at = 0;
  bit                    frame_done;
  int unsigned           cells_sent = 0;

  // 5x5 hand-made frame: every transition, both sides of each threshold under the
  // reset probabilities, non-wall borders that must pass through, walls inside
  cell_t demo_grid [DEMO_CELLS] = '{
    CELL_WALL, CELL_INF,  CELL_SUSC, CELL_REM,  CELL_WALL,
    CELL_SUSC, CELL_SUSC, CELL_INF,  CELL_REM,  CELL_INF,
    CELL_REM,  CELL_SUSC, CELL_REM,  CELL_WALL, CELL_SUSC,
    CELL_WALL, CELL_INF,  CELL_SUSC, CELL_SUSC, CELL_REM,
    CELL_SUSC, CELL_WALL, CELL_INF,  CELL_REM,  CELL_WALL
  };
  // Word k decides the cell at k-6; 26213/13107/13106/131/26214 straddle the thresholds
  logic [PROB_W-1:0] demo_words [DEMO_CELLS] = '{
    16'd65535, 16'd0,     16'd21845, 16'd43690, 16'd65535,
    16'd0,     16'd1,     16'd65534, 16'd32768, 16'd0,
    16'd65535, 16'd100,   16'd26213, 16'd13107, 16'd0,
    16'd65535, 16'd4660,  16'd13106, 16'd131,   16'd65535,
    16'd0,     16'd30000, 16'd0,     16'd26214, 16'd0
  };

  always #5 clk = ~clk;

  sirs_grid_automaton_step uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cell_state  (in_cell_state),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_state (out_next_state),
    .out_frame_last (out_frame_last)
  );

  sirs_generation_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cell_state  (in_cell_state),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_state (out_next_state),
    .out_frame_last (out_frame_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Receiver: a toggle on hold_toggle starts a long hold-off, counted here;
  // otherwise stall at random by stall_pct
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: give up once nothing has moved on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[sirs_grid_automaton_step] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int unsigned clamp_size(logic [DIM_BITS-1:0] v, int unsigned hi);
    int unsigned d;
    d = 32'(v);
    if (d < 3) return 3;
    if (d > hi) return hi;
    return d;
  endfunction

  // Write one register: setup cycle, access cycle, then the port goes idle
  task automatic write_reg(logic [2:0] idx, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH: begin
        cols_set = value[DIM_BITS-1:0];
        cols_eff = clamp_size(cols_set, MAX_WIDTH_DEF);
      end
      REG_HEIGHT: begin
        rows_set = value[DIM_BITS-1:0];
        rows_eff = clamp_size(rows_set, MAX_HEIGHT_DEF);
      end
      default: ;
    endcase
  endtask

  task automatic configure(logic [APB_DATA_W-1:0] w, logic [APB_DATA_W-1:0] h,
                           logic [APB_DATA_W-1:0] p_inf, logic [APB_DATA_W-1:0] p_rem,
                           logic [APB_DATA_W-1:0] p_ins);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_INFECT, p_inf);
    write_reg(REG_REMOVE, p_rem);
    write_reg(REG_REINSERT, p_ins);
  endtask

  // Offer one cell, hold it until taken, advance the raster position, then idle at random
  task automatic push_cell(logic [CELL_W-1:0] cell_val, logic [PROB_W-1:0] rnd);
    in_valid <= 1'b1;
    in_cell_state <= cell_val;
    in_random_word <= rnd;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    frame_done = (col_at + 1 >= cols_eff) && (row_at + 1 >= rows_eff);
    if (frame_done) begin
      col_at = 0;
      row_at = 0;
    end else if (col_at + 1 >= cols_eff) begin
      col_at = 0;
      row_at++;
    end else begin
      col_at++;
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Mostly walled borders, anything at all inside
  function automatic logic [CELL_W-1:0] pick_cell();
    bit                border;
    logic [CELL_W-1:0] c;
    border = col_at == 0 || col_at + 1 >= cols_eff || row_at == 0 || row_at + 1 >= rows_eff;
    c = CELL_W'($urandom_range(0, 3));
    if (border && $urandom_range(0, 9) < 7) c = CELL_WALL;
    return c;
  endfunction

  // Lean on both ends of the range so that low probabilities still fire now and then
  function automatic logic [PROB_W-1:0] pick_word();
    logic [PROB_W-1:0] r;
    case ($urandom_range(0, 3))
      0:       r = PROB_W'($urandom_range(0, 1023));
      1:       r = PROB_W'($urandom_range(64512, 65535));
      default: r = PROB_W'($urandom_range(0, 65535));
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_dim(int unsigned hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, hi);
  endfunction

  function automatic int unsigned pick_prob();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 600);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic send_frames(int unsigned n);
    repeat (n) begin
      do push_cell(pick_cell(), pick_word()); while (!frame_done);
    end
  endtask

  // Drop valid, wait out every expected result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 55; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 55; end
      default: begin idle_pct = 25; stall_pct <= 25; end
    endcase
  endtask

  initial begin
    int unsigned phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame: 5x5 under the reset probabilities, no idling
    set_idling(0);
    write_reg(REG_WIDTH, 5);
    write_reg(REG_HEIGHT, 5);
    foreach (demo_grid[i]) push_cell(demo_grid[i], demo_words[i]);
    drain();

    // Random phases of small grids; idling rotates through the four modes
    phase = 0;
    while (cells_sent < DEMO_CELLS + RANDOM_ITEMS) begin
      set_idling(phase % 4);
      if (phase == 1) begin
        // fill the block behind a long receiver hold while the sender keeps offering
        configure(12, 9, pick_prob(), pick_prob(), pick_prob());
        hold_toggle <= ~hold_toggle;
        send_frames(3);
      end else begin
        configure(pick_dim(14), pick_dim(9), pick_prob(), pick_prob(), pick_prob());
        send_frames($urandom_range(1, 3));
      end
      drain();
      phase++;
    end

    // Widest grid: width saturates to the maximum; run one full row and part of
    // the next, then narrow the grid so that the frame ends early
    set_idling(3);
    configure(2047, 3, $urandom_range(0, 65535), 65535, 0);
    repeat (MAX_WIDTH_DEF + 16) push_cell(pick_cell(), pick_word());
    drain();
    write_reg(REG_WIDTH, 3);
    do push_cell(pick_cell(), pick_word()); while (!frame_done);
    drain();

    // Tallest grid: height saturates to the maximum, width lifted to three;
    // cut the frame short by lowering the height after forty rows
    set_idling(0);
    configure(1, 2047, 65535, $urandom_range(0, 65535), 65535);
    repeat (120) push_cell(pick_cell(), pick_word());
    drain();
    write_reg(REG_HEIGHT, 3);
    do push_cell(pick_cell(), pick_word()); while (!frame_done);
    drain();

    // Shrink both sizes part-way through a frame, then run it out
    set_idling(2);
    configure(12, 10, 30000, 20000, 40000);
    repeat (40) push_cell(pick_cell(), pick_word());
    drain();
    write_reg(REG_WIDTH, 6);
    write_reg(REG_HEIGHT, 2);
    do push_cell(pick_cell(), pick_word()); while (!frame_done);
    drain();

    // Back to an ordinary grid to show the stream has recovered
    set_idling(1);
    configure(7, 5, pick_prob(), pick_prob(), pick_prob());
    send_frames(2);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[sirs_grid_automaton_step] OK");
    end else begin
      $display("[sirs_grid_automaton_step] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/sirsga_pkg.sv
design/sirsga_line_store.sv
design/sirs_grid_automaton_step.sv
test/sirs_generation_checker.sv
test/tb_sirs_grid_automaton_step.sv
